>>> hw/rtl/array_double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue.
// Shared helpers so that every checker line reads the same way.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ADQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adq assertion failed");

// Next-cycle implication, checked outside reset.
`define ADQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adq assertion failed");

`endif

>>> hw/rtl/adq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_pkg
// Types, codes and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package adq_pkg;

  // Default number of slots in the element store.
  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  // Action codes of an input item.
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Pointer and store operation for one cycle.
  typedef enum logic [2:0] {
    PTR_NONE,
    PTR_PUSH_FIRST,
    PTR_PUSH_BACK,
    PTR_PUSH_FRONT,
    PTR_POP_FRONT,
    PTR_POP_BACK,
    PTR_DUMP_START,
    PTR_DUMP_NEXT
  } ptr_op_e;

  // Output register load.
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_CODE,
    OUT_DATA
  } out_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch;
    ptr_op_e             ptr_op;
    out_op_e             out_op;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } adq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                empty;
    logic                at_front;
    logic                at_back;
    logic                walk_last;
    logic                out_last;
  } adq_status_t;

endpackage

>>> hw/rtl/adq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_in_if / adq_out_if
// Valid/ready channels for queue actions and for queue results.
// ----------------------------------------------------------------------------
interface adq_in_if;
  logic                              valid;
  logic                              ready;
  logic [adq_pkg::ACTION_W-1:0]      action;
  logic signed [adq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

interface adq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adq_pkg::DATA_W-1:0] out_value;
  logic [adq_pkg::STATUS_W-1:0]      status;
  logic                              last_of_run;

  modport source (output valid, output out_value, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input out_value, input status, input last_of_run,
                output ready);
endinterface

>>> hw/rtl/adq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_datapath
// Element store, head/tail/walk pointers, input latch and output register.
// ----------------------------------------------------------------------------
`include "array_double_ended_queue_defines.svh"

module adq_datapath #(
  parameter int unsigned DEPTH = adq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  adq_pkg::adq_cmd_t                   cmd_i,
  input  logic [adq_pkg::ACTION_W-1:0]        in_action_i,
  input  logic signed [adq_pkg::DATA_W-1:0]   in_push_value_i,
  output adq_pkg::adq_status_t                status_o,
  output logic signed [adq_pkg::DATA_W-1:0]   out_value_o,
  output logic [adq_pkg::STATUS_W-1:0]        out_status_o,
  output logic                                out_last_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  // Latched input item.
  logic [adq_pkg::ACTION_W-1:0]      action_q;
  logic signed [adq_pkg::DATA_W-1:0] value_q;

  // Pointers.
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] walk_q, walk_d;
  logic             empty_q, empty_d;

  // Store ports.
  logic                              we;
  logic [PTR_W-1:0]                  waddr;
  logic [PTR_W-1:0]                  raddr;
  logic signed [adq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [adq_pkg::DATA_W-1:0] rdata_q;

  // Output register.
  logic signed [adq_pkg::DATA_W-1:0] out_value_q;
  logic [adq_pkg::STATUS_W-1:0]      out_status_q;
  logic                              out_last_q;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= in_action_i;
      value_q  <= in_push_value_i;
    end
  end

  // Pointer updates and store addressing for the commanded operation.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    walk_d  = walk_q;
    empty_d = empty_q;
    we      = 1'b0;
    waddr   = tail_q;
    raddr   = walk_q;
    case (cmd_i.ptr_op)
      adq_pkg::PTR_PUSH_FIRST: begin
        we      = 1'b1;
        waddr   = '0;
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
      end
      adq_pkg::PTR_PUSH_BACK: begin
        we     = 1'b1;
        waddr  = tail_q + 1'b1;
        tail_d = tail_q + 1'b1;
      end
      adq_pkg::PTR_PUSH_FRONT: begin
        we     = 1'b1;
        waddr  = head_q - 1'b1;
        head_d = head_q - 1'b1;
      end
      adq_pkg::PTR_POP_FRONT: begin
        raddr = head_q;
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          head_d = head_q + 1'b1;
        end
      end
      adq_pkg::PTR_POP_BACK: begin
        raddr = tail_q;
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          tail_d = tail_q - 1'b1;
        end
      end
      adq_pkg::PTR_DUMP_START: begin
        raddr  = head_q;
        walk_d = head_q;
      end
      adq_pkg::PTR_DUMP_NEXT: begin
        raddr  = walk_q + 1'b1;
        walk_d = walk_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      walk_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      walk_q  <= walk_d;
      empty_q <= empty_d;
    end
  end

  // Element store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_q;
    end
    rdata_q <= mem[raddr];
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.out_op)
      adq_pkg::OUT_CODE: begin
        out_value_q  <= '0;
        out_status_q <= cmd_i.out_status;
      end
      adq_pkg::OUT_DATA: begin
        out_value_q  <= rdata_q;
        out_status_q <= adq_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  // The last flag steers the controller, so it is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_last_q <= 1'b1;
    end else if (cmd_i.out_op != adq_pkg::OUT_NONE) begin
      out_last_q <= cmd_i.out_last;
    end
  end

  assign status_o.action    = action_q;
  assign status_o.empty     = empty_q;
  assign status_o.at_front  = (head_q == '0);
  assign status_o.at_back   = (tail_q == LAST_SLOT);
  assign status_o.walk_last = (walk_q == tail_q);
  assign status_o.out_last  = out_last_q;

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  // An empty queue keeps both pointers parked at slot zero.
  `ADQ_ASSERT_IMPL(a_empty_parked, clk_i, rst_ni, empty_q, (head_q == '0) && (tail_q == '0))
  // A live queue never has its head past its tail.
  `ADQ_ASSERT_IMPL(a_head_le_tail, clk_i, rst_ni, !empty_q, head_q <= tail_q)
  // A back push moves the tail by exactly one slot.
  `ADQ_ASSERT_NEXT(a_push_back_step, clk_i, rst_ni, cmd_i.ptr_op == adq_pkg::PTR_PUSH_BACK, tail_q == PTR_W'($past(tail_q) + 1'b1))

endmodule

>>> hw/rtl/adq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_ctrl
// Sequencer for one action at a time: decode, store access, result hand-off.
// ----------------------------------------------------------------------------
`include "array_double_ended_queue_defines.svh"

module adq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  adq_pkg::adq_status_t status_i,
  output adq_pkg::adq_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.out_last = 1'b1;
        case (status_i.action)
          adq_pkg::ACT_PUSH_BACK, adq_pkg::ACT_PUSH_FRONT: begin
            cmd_o.out_op = adq_pkg::OUT_CODE;
            state_d      = S_OUT;
            if (status_i.empty) begin
              cmd_o.ptr_op     = adq_pkg::PTR_PUSH_FIRST;
              cmd_o.out_status = adq_pkg::ST_OK;
            end else if (status_i.action == adq_pkg::ACT_PUSH_BACK) begin
              if (status_i.at_back) begin
                cmd_o.out_status = adq_pkg::ST_FULL;
              end else begin
                cmd_o.ptr_op     = adq_pkg::PTR_PUSH_BACK;
                cmd_o.out_status = adq_pkg::ST_OK;
              end
            end else begin
              if (status_i.at_front) begin
                cmd_o.out_status = adq_pkg::ST_FULL;
              end else begin
                cmd_o.ptr_op     = adq_pkg::PTR_PUSH_FRONT;
                cmd_o.out_status = adq_pkg::ST_OK;
              end
            end
          end
          adq_pkg::ACT_POP_FRONT, adq_pkg::ACT_POP_BACK, adq_pkg::ACT_DUMP: begin
            if (status_i.empty) begin
              cmd_o.out_op     = adq_pkg::OUT_CODE;
              cmd_o.out_status = adq_pkg::ST_EMPTY;
              state_d          = S_OUT;
            end else begin
              state_d = S_READ;
              if (status_i.action == adq_pkg::ACT_POP_FRONT) begin
                cmd_o.ptr_op = adq_pkg::PTR_POP_FRONT;
              end else if (status_i.action == adq_pkg::ACT_POP_BACK) begin
                cmd_o.ptr_op = adq_pkg::PTR_POP_BACK;
              end else begin
                cmd_o.ptr_op = adq_pkg::PTR_DUMP_START;
              end
            end
          end
          default: begin
            // Undefined actions give no result.
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // Store data is ready; a dump marks only the back element as last.
        cmd_o.out_op   = adq_pkg::OUT_DATA;
        cmd_o.out_last = (status_i.action != adq_pkg::ACT_DUMP) || status_i.walk_last;
        state_d        = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_op = adq_pkg::PTR_DUMP_NEXT;
            state_d      = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode lasts exactly one cycle.
  `ADQ_ASSERT_NEXT(a_exec_once, clk_i, rst_ni, state_q == S_EXEC, state_q != S_EXEC)
  // A store read is always followed by a result on offer.
  `ADQ_ASSERT_NEXT(a_read_to_out, clk_i, rst_ni, state_q == S_READ, state_q == S_OUT)
  // Only a dump produces results that are not last.
  `ADQ_ASSERT_IMPL(a_more_only_dump, clk_i, rst_ni, (state_q == S_OUT) && !status_i.out_last, status_i.action == adq_pkg::ACT_DUMP)

endmodule

>>> hw/rtl/array_double_ended_queue.sv
// Push and error items: accept (IDLE), decode (EXEC), then the result is offered (OUT).
// Pops: accept, decode, one registered store read (READ), then the result is offered (OUT).
// Dump: first element as for pops; each further one passes through READ again after the last is taken.
// One item at a time: the next item is accepted the cycle after its last result is taken.
// Reset (asynchronous, active low) empties the queue; store contents are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_double_ended_queue
// Double-ended queue of signed words in a fixed, non-wrapping store.
// ----------------------------------------------------------------------------
module array_double_ended_queue #(
  parameter int unsigned DEPTH = adq_pkg::DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  adq_in_if.sink     in_i,
  adq_out_if.source  out_o
);

  adq_pkg::adq_cmd_t    cmd;
  adq_pkg::adq_status_t status;

  // Sequencer.
  adq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Store, pointers and result register.
  adq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_action_i     (in_i.action),
    .in_push_value_i (in_i.push_value),
    .status_o        (status),
    .out_value_o     (out_o.out_value),
    .out_status_o    (out_o.status),
    .out_last_o      (out_o.last_of_run)
  );

endmodule
